### rtl/pmt_pkg.sv
// Shared constants and codes for the pointer motion tracker.
`default_nettype none

package pmt_pkg;

  localparam int MOTION_BITS_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;

  localparam int DIM_W     = 13;
  localparam int FLAG_W    = 16;
  localparam int GAIN_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int KIND_W    = 2;
  localparam int BTN_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MASK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MASK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_MASK   = 3'd5;

  localparam logic [KIND_W-1:0] EV_MOVE = 2'd0;
  localparam logic [KIND_W-1:0] EV_DOWN = 2'd1;
  localparam logic [KIND_W-1:0] EV_UP   = 2'd2;

  localparam logic [BTN_W-1:0] BTN_NONE   = 2'd0;
  localparam logic [BTN_W-1:0] BTN_LEFT   = 2'd1;
  localparam logic [BTN_W-1:0] BTN_RIGHT  = 2'd2;
  localparam logic [BTN_W-1:0] BTN_MIDDLE = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RST   = 32'd1;
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd480;
  localparam logic [FLAG_W-1:0] LEFT_RST   = 16'd1;
  localparam logic [FLAG_W-1:0] RIGHT_RST  = 16'd2;
  localparam logic [FLAG_W-1:0] MIDDLE_RST = 16'd4;

endpackage

`default_nettype wire

### rtl/pmt_div.sv
// Shared restoring divider producing one quotient bit per cycle.
`default_nettype none

module pmt_div #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  dsr_q;

  logic [W:0]   shifted;
  logic [W+1:0] trial;
  logic         ge;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
  assign ge      = ~trial[W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CW'(W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### rtl/pmt_mul.sv
// Shared registered multiplier keeping the low word of the product.
`default_nettype none

module pmt_mul #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] p_o
);

  logic [W-1:0] full;
  logic [W-1:0] prod_q;

  assign full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= full;
    end
  end

  assign p_o = prod_q;

endmodule

`default_nettype wire

### rtl/pointer_motion_tracker.sv
// Pointer motion tracker: accelerated position update, screen scaling and event output.
// An item is taken only while idle, so a new item waits until the results of the last one are out;
// a second result, a button event, can follow the move result when both are due.
// The shared divider does four divisions per item at one bit a cycle.
// Reset clears positions and previous flags to zero and loads the register reset values.
`default_nettype none

module pointer_motion_tracker #(
  parameter int MOTION_BITS   = pmt_pkg::MOTION_BITS_DEF,
  parameter int POSITION_BITS = pmt_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pmt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pmt_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [MOTION_BITS-1:0]     motion_x_i,
  input  logic signed [MOTION_BITS-1:0]     motion_y_i,
  input  logic [pmt_pkg::FLAG_W-1:0]        button_flags_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pmt_pkg::KIND_W-1:0]        event_kind_o,
  output logic [pmt_pkg::DIM_W-1:0]         screen_x_o,
  output logic [pmt_pkg::DIM_W-1:0]         screen_y_o,
  output logic [pmt_pkg::BTN_W-1:0]         button_number_o,
  output logic                              last_of_run_o
);

  import pmt_pkg::*;

  localparam int MB    = MOTION_BITS;
  localparam int PB    = POSITION_BITS;
  localparam int LEN_W = $clog2(MB + 1);
  localparam int EXT_W = (MB > PB) ? MB : PB;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_G,
    ST_ADD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  function automatic logic [LEN_W-1:0] bit_len(input logic [MB-1:0] v);
    logic [LEN_W-1:0] r;
    r = '0;
    for (int i = 0; i < MB; i++) begin
      if (v[i]) begin
        r = LEN_W'(i + 1);
      end
    end
    return r;
  endfunction

  state_e st_q;

  logic [GAIN_W-1:0] gain_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic [FLAG_W-1:0] left_q;
  logic [FLAG_W-1:0] right_q;
  logic [FLAG_W-1:0] middle_q;

  logic [PB-1:0]     pos_x_q;
  logic [PB-1:0]     pos_y_q;
  logic [FLAG_W-1:0] prev_flags_q;

  logic [MB-1:0]     x_mag_q;
  logic [MB-1:0]     y_mag_q;
  logic              x_neg_q;
  logic              y_neg_q;
  logic [FLAG_W-1:0] flags_q;
  logic [FLAG_W-1:0] old_q;
  logic              axis_q;
  logic [1:0]        div_op_q;
  logic [PB-1:0]     scale_q;
  logic [DIM_W-1:0]  sx_q;
  logic [DIM_W-1:0]  sy_q;
  logic              pend_move_q;
  logic              pend_btn_q;

  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [DIM_W-1:0]  out_sx_q;
  logic [DIM_W-1:0]  out_sy_q;
  logic [BTN_W-1:0]  btn_q;
  logic              last_q;

  logic [MB-1:0]     mx;
  logic [MB-1:0]     my;
  logic [MB-1:0]     x_mag_d;
  logic [MB-1:0]     y_mag_d;

  logic [MB-1:0]     cur_mag;
  logic              cur_neg;
  logic [PB-1:0]     cur_pos;
  logic [EXT_W-1:0]  mag_wide;
  logic [PB-1:0]     mul_a;
  logic [PB-1:0]     mul_b;
  logic              mul_en;
  logic [PB-1:0]     prod;
  logic [PB-1:0]     delta;
  logic [PB-1:0]     sum;
  logic [PB-1:0]     next_pos_d;

  logic [DIM_W-1:0]  dim;
  logic [DIM_W-1:0]  dim_m1;
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [PB-1:0]     div_q;
  logic [PB-1:0]     dividend;
  logic [PB-1:0]     divisor;

  logic              flags_up;
  logic [FLAG_W-1:0] diff;
  logic [BTN_W-1:0]  btn_sel;
  logic [KIND_W-1:0] btn_kind;
  logic              slot_free;
  logic              emit;

  assign mx      = motion_x_i;
  assign my      = motion_y_i;
  assign x_mag_d = mx[MB-1] ? (~mx + 1'b1) : mx;
  assign y_mag_d = my[MB-1] ? (~my + 1'b1) : my;

  assign cur_mag  = axis_q ? y_mag_q : x_mag_q;
  assign cur_neg  = axis_q ? y_neg_q : x_neg_q;
  assign cur_pos  = axis_q ? pos_y_q : pos_x_q;
  assign mag_wide = EXT_W'(cur_mag);

  assign mul_en = (st_q == ST_MUL_L) || (st_q == ST_MUL_G);
  assign mul_a  = (st_q == ST_MUL_L) ? mag_wide[PB-1:0] : prod;
  assign mul_b  = (st_q == ST_MUL_L) ? PB'(bit_len(cur_mag)) : gain_q[PB-1:0];

  pmt_mul #(.W(PB)) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    delta      = cur_neg ? (~prod + 1'b1) : prod;
    sum        = cur_pos + delta;
    next_pos_d = sum;
    if (!cur_neg && (sum < cur_pos)) begin
      next_pos_d = '1;
    end
    if (cur_neg && (sum > cur_pos)) begin
      next_pos_d = '0;
    end
  end

  assign dim       = div_op_q[1] ? height_q : width_q;
  assign dim_m1    = (dim < DIM_W'(2)) ? DIM_W'(1) : (dim - 1'b1);
  assign dividend  = div_op_q[0] ? (div_op_q[1] ? pos_y_q : pos_x_q) : '1;
  assign divisor   = div_op_q[0] ? scale_q : PB'(dim_m1);
  assign div_start = (st_q == ST_DIV_START);

  pmt_div #(.W(PB)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    flags_up = flags_q > old_q;
    diff     = flags_up ? (flags_q - old_q) : (old_q - flags_q);
    btn_kind = flags_up ? EV_DOWN : EV_UP;
    btn_sel  = BTN_NONE;
    if (diff == left_q) begin
      btn_sel = BTN_LEFT;
    end
    if (diff == right_q) begin
      btn_sel = BTN_RIGHT;
    end
    if (diff == middle_q) begin
      btn_sel = BTN_MIDDLE;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = (st_q == ST_EMIT) && slot_free && (pend_move_q || pend_btn_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      left_q   <= LEFT_RST;
      right_q  <= RIGHT_RST;
      middle_q <= MIDDLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SPEED_GAIN:    gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        CFG_LEFT_MASK:     left_q   <= cfg_data_i[FLAG_W-1:0];
        CFG_RIGHT_MASK:    right_q  <= cfg_data_i[FLAG_W-1:0];
        CFG_MIDDLE_MASK:   middle_q <= cfg_data_i[FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      prev_flags_q <= '0;
      x_mag_q      <= '0;
      y_mag_q      <= '0;
      x_neg_q      <= 1'b0;
      y_neg_q      <= 1'b0;
      flags_q      <= '0;
      old_q        <= '0;
      axis_q       <= 1'b0;
      div_op_q     <= '0;
      scale_q      <= '0;
      sx_q         <= '0;
      sy_q         <= '0;
      pend_move_q  <= 1'b0;
      pend_btn_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      kind_q       <= EV_MOVE;
      out_sx_q     <= '0;
      out_sy_q     <= '0;
      btn_q        <= BTN_NONE;
      last_q       <= 1'b0;
    end else begin
      if (out_ready_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            x_mag_q      <= x_mag_d;
            y_mag_q      <= y_mag_d;
            x_neg_q      <= mx[MB-1];
            y_neg_q      <= !my[MB-1] && (y_mag_d != '0);
            flags_q      <= button_flags_i;
            old_q        <= prev_flags_q;
            prev_flags_q <= button_flags_i;
            axis_q       <= 1'b0;
            st_q         <= ST_MUL_L;
          end
        end
        ST_MUL_L: st_q <= ST_MUL_G;
        ST_MUL_G: st_q <= ST_ADD;
        ST_ADD: begin
          if (axis_q) begin
            pos_y_q  <= next_pos_d;
            div_op_q <= '0;
            st_q     <= ST_DIV_START;
          end else begin
            pos_x_q <= next_pos_d;
            axis_q  <= 1'b1;
            st_q    <= ST_MUL_L;
          end
        end
        ST_DIV_START: st_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            case (div_op_q)
              2'd1:    sx_q    <= div_q[DIM_W-1:0];
              2'd3:    sy_q    <= div_q[DIM_W-1:0];
              default: scale_q <= div_q;
            endcase
            if (div_op_q == 2'd3) begin
              pend_move_q <= (x_mag_q != '0) || (y_mag_q != '0);
              pend_btn_q  <= (flags_q != old_q) && (btn_sel != BTN_NONE);
              st_q        <= ST_EMIT;
            end else begin
              div_op_q <= div_op_q + 1'b1;
              st_q     <= ST_DIV_START;
            end
          end
        end
        ST_EMIT: begin
          if (!pend_move_q && !pend_btn_q) begin
            st_q <= ST_IDLE;
          end else if (slot_free) begin
            out_valid_q <= 1'b1;
            out_sx_q    <= sx_q;
            out_sy_q    <= sy_q;
            if (pend_move_q) begin
              kind_q      <= EV_MOVE;
              btn_q       <= BTN_NONE;
              last_q      <= !pend_btn_q;
              pend_move_q <= 1'b0;
              if (!pend_btn_q) begin
                st_q <= ST_IDLE;
              end
            end else begin
              kind_q     <= btn_kind;
              btn_q      <= btn_sel;
              last_q     <= 1'b1;
              pend_btn_q <= 1'b0;
              st_q       <= ST_IDLE;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (st_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign screen_x_o      = out_sx_q;
  assign screen_y_o      = out_sy_q;
  assign button_number_o = btn_q;
  assign last_of_run_o   = last_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("Divider restarted while busy.");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == ST_DIV_WAIT))
    else $error("Divider result arrived outside the wait state.");

  a_pos_x_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_ADD && !axis_q && !x_neg_q) |=> (pos_x_q >= $past(pos_x_q)))
    else $error("Positive motion moved the position backward.");

  a_btn_event_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_kind_o != EV_MOVE)) |-> (button_number_o != BTN_NONE))
    else $error("Button event without a button number.");

  a_move_event_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_kind_o == EV_MOVE)) |-> (button_number_o == BTN_NONE))
    else $error("Move event carries a button number.");

endmodule

`default_nettype wire
